// ===== rtl/core/idci_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idci_pkg
// Shared types, register offsets and helpers of the interrupt controller.
// ----------------------------------------------------------------------------
package idci_pkg;

  localparam int NUM_IRQS_DEFAULT = 1024;

  localparam logic [2:0] OP_DIST_RD = 3'd0;
  localparam logic [2:0] OP_DIST_WR = 3'd1;
  localparam logic [2:0] OP_CPU_RD  = 3'd2;
  localparam logic [2:0] OP_CPU_WR  = 3'd3;
  localparam logic [2:0] OP_LINE    = 3'd4;

  localparam logic [11:0] OFF_CTRL     = 12'h000;
  localparam logic [11:0] OFF_PMASK    = 12'h004;
  localparam logic [11:0] OFF_ACK      = 12'h00C;
  localparam logic [11:0] OFF_EOI      = 12'h010;
  localparam logic [11:0] OFF_SET_BASE = 12'h100;
  localparam logic [11:0] OFF_CLR_BASE = 12'h180;
  localparam logic [11:0] OFF_EN_END   = 12'h200;

  localparam logic [31:0] SPURIOUS_ID = 32'd1023;

  typedef enum logic [2:0] {
    K_REG,
    K_EN_RD,
    K_EN_SET,
    K_EN_CLR,
    K_ACK,
    K_EOI,
    K_LINE
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UPDATE,
    S_SCAN,
    S_CLAIM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_start;
    logic scan_step;
    logic update;
    logic claim;
    logic spurious;
    logic emit;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  scan_hit;
    logic  scan_end;
  } status_t;

  function automatic logic [4:0] first_set(input logic [31:0] w);
    logic [4:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (w[i]) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/idci_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idci_ctrl
// Sequencer: steps each request through decode, row update or scan, and
// holds the result valid until it is taken.
// ----------------------------------------------------------------------------
module idci_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire idci_pkg::status_t status,
  output idci_pkg::cmd_t         cmd
);
  import idci_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.kind == K_ACK) begin
          state_next = S_SCAN;
        end else if (status.kind == K_REG) begin
          state_next = S_DONE;
        end else begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: state_next = S_DONE;
      S_SCAN: begin
        if (status.scan_hit) begin
          state_next = S_CLAIM;
        end else if (status.scan_end) begin
          state_next = S_DONE;
        end
      end
      S_CLAIM: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DECODE: begin
        cmd.exec       = 1'b1;
        cmd.scan_start = (status.kind == K_ACK);
      end
      S_UPDATE: cmd.update = 1'b1;
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.spurious  = !status.scan_hit && status.scan_end;
      end
      S_CLAIM: cmd.claim = 1'b1;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/idci_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idci_datapath
// Request registers, register decode, control registers and the enable,
// pending and active bit stores kept as 32-bit rows.
// ----------------------------------------------------------------------------
module idci_datapath #(
  parameter int NUM_IRQS = idci_pkg::NUM_IRQS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [2:0]        operation,
  input  wire logic [11:0]       offset,
  input  wire logic [31:0]       write_data,
  input  wire logic [10:0]       irq_number,
  input  wire logic              irq_level,
  input  wire idci_pkg::cmd_t    cmd,
  output idci_pkg::status_t      status,
  output logic [31:0]            read_data
);
  import idci_pkg::*;

  localparam int NumWords = (NUM_IRQS + 31) / 32;
  localparam int RowW     = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int CntW     = $clog2(NumWords + 1);

  logic [2:0]  cur_op;
  logic [11:0] cur_offset;
  logic [31:0] cur_data;
  logic [10:0] cur_id;
  logic        cur_level;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_op     <= operation;
      cur_offset <= offset;
      cur_data   <= write_data;
      cur_id     <= irq_number;
      cur_level  <= irq_level;
    end
  end

  // register decode
  kind_t       kind;
  logic [5:0]  row_full;
  logic [4:0]  bit_idx;
  logic [31:0] reg_rdata;
  logic        dist_en_we;
  logic        cpu_en_we;
  logic        pmask_we;
  logic        dist_en;
  logic        cpu_en;
  logic [7:0]  pmask;

  always_comb begin
    kind       = K_REG;
    row_full   = '0;
    bit_idx    = '0;
    reg_rdata  = '0;
    dist_en_we = 1'b0;
    cpu_en_we  = 1'b0;
    pmask_we   = 1'b0;
    case (cur_op)
      OP_DIST_RD: begin
        if (cur_offset == OFF_CTRL) begin
          reg_rdata = {31'b0, dist_en};
        end else if (cur_offset inside {[OFF_SET_BASE:OFF_CLR_BASE - 12'd1]}) begin
          row_full = {1'b0, cur_offset[6:2]};
          if (row_full < 6'(NumWords)) begin
            kind = K_EN_RD;
          end
        end
      end
      OP_DIST_WR: begin
        if (cur_offset == OFF_CTRL) begin
          dist_en_we = 1'b1;
        end else if (cur_offset inside {[OFF_SET_BASE:OFF_CLR_BASE - 12'd1]}) begin
          row_full = {1'b0, cur_offset[6:2]};
          if (row_full < 6'(NumWords)) begin
            kind = K_EN_SET;
          end
        end else if (cur_offset inside {[OFF_CLR_BASE:OFF_EN_END - 12'd1]}) begin
          row_full = {1'b0, cur_offset[6:2]};
          if (row_full < 6'(NumWords)) begin
            kind = K_EN_CLR;
          end
        end
      end
      OP_CPU_RD: begin
        if (cur_offset == OFF_CTRL) begin
          reg_rdata = {31'b0, cpu_en};
        end else if (cur_offset == OFF_PMASK) begin
          reg_rdata = {24'b0, pmask};
        end else if (cur_offset == OFF_ACK) begin
          kind = K_ACK;
        end
      end
      OP_CPU_WR: begin
        if (cur_offset == OFF_CTRL) begin
          cpu_en_we = 1'b1;
        end else if (cur_offset == OFF_PMASK) begin
          pmask_we = 1'b1;
        end else if (cur_offset == OFF_EOI) begin
          row_full = {1'b0, cur_data[9:5]};
          bit_idx  = cur_data[4:0];
          if ({1'b0, cur_data[9:0]} < 11'(NUM_IRQS)) begin
            kind = K_EOI;
          end
        end
      end
      OP_LINE: begin
        row_full = cur_id[10:5];
        bit_idx  = cur_id[4:0];
        if (cur_id < 11'(NUM_IRQS)) begin
          kind = K_LINE;
        end
      end
      default: ;
    endcase
  end

  logic [RowW-1:0] target_row;
  assign target_row = row_full[RowW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_en <= 1'b0;
      cpu_en  <= 1'b0;
      pmask   <= '0;
    end else if (cmd.exec) begin
      if (dist_en_we) begin
        dist_en <= cur_data[0];
      end
      if (cpu_en_we) begin
        cpu_en <= cur_data[0];
      end
      if (pmask_we) begin
        pmask <= cur_data[7:0];
      end
    end
  end

  // bit stores, one row per 32 interrupts
  logic [31:0]         en_mem   [NumWords];
  logic [31:0]         pend_mem [NumWords];
  logic [31:0]         act_mem  [NumWords];
  logic [NumWords-1:0] en_vld;
  logic [NumWords-1:0] pend_vld;
  logic [NumWords-1:0] act_vld;

  logic [CntW-1:0] scan_cnt;
  logic            scan_in_range;
  logic            rd_en;
  logic [RowW-1:0] rd_addr;
  logic [31:0]     en_raw, pend_raw, act_raw;
  logic            en_ok, pend_ok, act_ok;
  logic            rd_ok;
  logic [RowW-1:0] rd_row;

  assign scan_in_range = scan_cnt < CntW'(NumWords);
  assign rd_en   = (cmd.exec && kind != K_REG && kind != K_ACK) ||
                   (cmd.scan_step && scan_in_range);
  assign rd_addr = cmd.scan_step ? scan_cnt[RowW-1:0] : target_row;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      en_raw   <= en_mem[rd_addr];
      pend_raw <= pend_mem[rd_addr];
      act_raw  <= act_mem[rd_addr];
      en_ok    <= en_vld[rd_addr];
      pend_ok  <= pend_vld[rd_addr];
      act_ok   <= act_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok    <= 1'b0;
      scan_cnt <= '0;
    end else if (cmd.scan_start) begin
      rd_ok    <= 1'b0;
      scan_cnt <= '0;
    end else if (cmd.scan_step) begin
      rd_ok <= scan_in_range;
      if (scan_in_range) begin
        scan_cnt <= scan_cnt + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && scan_in_range) begin
      rd_row <= scan_cnt[RowW-1:0];
    end
  end

  logic [31:0] en_w, pend_w, act_w, hits;
  assign en_w   = en_ok ? en_raw : '0;
  assign pend_w = pend_ok ? pend_raw : '0;
  assign act_w  = act_ok ? act_raw : '0;
  assign hits   = en_w & pend_w;

  assign status = '{
    kind:     kind,
    scan_hit: rd_ok && (|hits),
    scan_end: rd_ok && !(|hits) && (rd_row == RowW'(NumWords - 1))
  };

  // winner of the scan
  logic [RowW-1:0] claim_row;
  logic [4:0]      claim_bit;
  logic [31:0]     claim_pend, claim_act;

  always_ff @(posedge clk) begin
    if (cmd.scan_step && status.scan_hit) begin
      claim_row  <= rd_row;
      claim_bit  <= first_set(hits);
      claim_pend <= pend_w;
      claim_act  <= act_w;
    end
  end

  // row write-back
  logic [RowW-1:0] wr_row;
  logic            en_we, pend_we, act_we;
  logic [31:0]     en_wd, pend_wd, act_wd;
  logic [31:0]     row_mask, bit_oh, claim_oh;
  int              lim;

  assign bit_oh   = 32'(1) << bit_idx;
  assign claim_oh = 32'(1) << claim_bit;

  always_comb begin
    lim      = NUM_IRQS - 32 * int'(target_row);
    row_mask = (lim >= 32) ? '1 : ((32'(1) << lim) - 32'd1);
  end

  always_comb begin
    wr_row  = target_row;
    en_we   = 1'b0;
    pend_we = 1'b0;
    act_we  = 1'b0;
    en_wd   = en_w;
    pend_wd = pend_w;
    act_wd  = act_w;
    if (cmd.update) begin
      case (kind)
        K_EN_SET: begin
          en_we = 1'b1;
          en_wd = en_w | (cur_data & row_mask);
        end
        K_EN_CLR: begin
          en_we = 1'b1;
          en_wd = en_w & ~(cur_data & row_mask);
        end
        K_EOI: begin
          act_we = 1'b1;
          act_wd = act_w & ~bit_oh;
        end
        K_LINE: begin
          pend_we = 1'b1;
          pend_wd = cur_level ? (pend_w | bit_oh) : (pend_w & ~bit_oh);
        end
        default: ;
      endcase
    end else if (cmd.claim) begin
      wr_row  = claim_row;
      pend_we = 1'b1;
      pend_wd = claim_pend & ~claim_oh;
      act_we  = 1'b1;
      act_wd  = claim_act | claim_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (en_we) begin
      en_mem[wr_row] <= en_wd;
    end
    if (pend_we) begin
      pend_mem[wr_row] <= pend_wd;
    end
    if (act_we) begin
      act_mem[wr_row] <= act_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      en_vld   <= '0;
      pend_vld <= '0;
      act_vld  <= '0;
    end else begin
      if (en_we) begin
        en_vld[wr_row] <= 1'b1;
      end
      if (pend_we) begin
        pend_vld[wr_row] <= 1'b1;
      end
      if (act_we) begin
        act_vld[wr_row] <= 1'b1;
      end
    end
  end

  // result
  logic [31:0] res;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res <= (kind == K_REG) ? reg_rdata : '0;
    end else if (cmd.update) begin
      res <= (kind == K_EN_RD) ? en_w : '0;
    end else if (cmd.spurious) begin
      res <= SPURIOUS_ID;
    end else if (cmd.claim) begin
      res <= 32'({claim_row, claim_bit});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      read_data <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/interrupt_distributor_cpu_interface.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interrupt_distributor_cpu_interface
// Simplified interrupt distributor and cpu interface with acknowledge scan.
// ----------------------------------------------------------------------------
// Usage:
//   One request per in_valid/in_ready handshake: a distributor or cpu register
//   access, or an interrupt line level change. Every request returns exactly
//   one read_data word on the out_valid/out_ready channel (0 for writes).
//   Control registers and unknown offsets pass from decode straight to the
//   result; enable, end-of-interrupt and line requests add one update step
//   (one read-modify-write of a 32-bit row); an acknowledge scans the
//   ceil(NUM_IRQS / 32) rows of the enable and pending stores; the scan reads
//   one row per cycle, stops at the first hit and then claims it.
//   One request is in flight at a time; in_ready rises the cycle after the
//   result is loaded into the output register, so the next request is
//   processed while a result waits for out_ready.
//   Reset clears all enable, pending and active bits (per-row valid flags,
//   no clearing pass) and the control registers; no result is pending.
//   If the receiver stalls, read_data holds and at most one finished
//   request waits in the sequencer behind it.
// ----------------------------------------------------------------------------
module interrupt_distributor_cpu_interface #(
  parameter int NUM_IRQS = idci_pkg::NUM_IRQS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [11:0] offset,
  input  wire logic [31:0] write_data,
  input  wire logic [10:0] irq_number,
  input  wire logic        irq_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_data
);
  import idci_pkg::*;

  cmd_t    cmd;
  status_t status;

  idci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  idci_datapath #(
    .NUM_IRQS (NUM_IRQS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .operation  (operation),
    .offset     (offset),
    .write_data (write_data),
    .irq_number (irq_number),
    .irq_level  (irq_level),
    .cmd        (cmd),
    .status     (status),
    .read_data  (read_data)
  );

`ifndef SYNTHESIS
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

  a_hit_or_end : assert property (@(posedge clk) disable iff (rst)
    status.scan_hit |-> !status.scan_end)
    else $error("scan reports hit and end together");

  a_emit_valid : assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result emitted without out_valid");
`endif

endmodule
`default_nettype wire
